FILE: hw/rtl/dicdf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the discrete inverse-CDF sampler.
// No dependencies; dicdf_walker and the top level import this package.
package dicdf_pkg;

   // action codes carried by an input item
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_DRAW  = 1'b1;

   typedef struct packed {
      logic               action;
      logic [7:0]         entry_index;
      logic signed [31:0] outcome_value;
      logic [15:0]        weight;
      logic [31:0]        uniform;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic [7:0]         sample_index;
      logic               empty_table;
   } rsp_type;

endpackage

FILE: hw/rtl/dicdf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dicdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/dicdf_walker.sv
`timescale 1ns / 1ps
// Sequencer for the sampler: clearing pass, table writes, sum pass, scaling
// multiply and prefix search over the weight and outcome memories. Uses dicdf_pkg.
module dicdf_walker
   import dicdf_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  req_type                        req_item,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   output logic                           busy,
   output logic                           rsp_strobe,
   output rsp_type                        rsp_item,
   output logic                           wgt_we,
   output logic                           out_we,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
   output logic [15:0]                    wgt_wdata,
   output logic [31:0]                    out_wdata,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
   input  logic [15:0]                    wgt_rdata,
   input  logic [31:0]                    out_rdata
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_W = 16 + AW;
   localparam int PW    = 32 + TOT_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SUM    = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_CEIL   = 6'b010000,
      ST_SEARCH = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  prefix_ff, prefix_in;
   logic [TOT_W-1:0]  need_ff, need_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [31:0]       uni_ff, uni_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;
   logic              issuing;
   logic              accept;
   logic              in_range;
   logic [TOT_W-1:0]  prefix_sum;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = 32'(req_item.entry_index) < 32'(TABLE_DEPTH);
   assign issuing  = ((state_ff == ST_SUM) || (state_ff == ST_SEARCH)) && (iss_ff < count);
   assign prefix_sum = prefix_ff + TOT_W'(wgt_rdata);

   // write port: clearing pass owns it after reset, then write items
   always_comb begin
      wgt_we    = 1'b0;
      out_we    = 1'b0;
      ram_waddr = AW'(req_item.entry_index);
      wgt_wdata = req_item.weight;
      out_wdata = req_item.outcome_value;
      if (state_ff == ST_CLEAR) begin
         wgt_we    = 1'b1;
         ram_waddr = iss_ff[AW-1:0];
         wgt_wdata = '0;
      end else if (accept && (req_item.action == ACT_WRITE) && in_range) begin
         wgt_we = 1'b1;
         out_we = 1'b1;
      end
   end

   assign ram_raddr = iss_ff[AW-1:0];

   always_comb begin
      state_in  = state_ff;
      iss_in    = iss_ff;
      rd_vld_in = issuing;
      rd_idx_in = issuing ? iss_ff[AW-1:0] : rd_idx_ff;
      total_in  = total_ff;
      prefix_in = prefix_ff;
      need_in   = need_ff;
      prod_in   = prod_ff;
      uni_in    = uni_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      if (issuing) begin
         iss_in = iss_ff + CNT_W'(1);
      end
      unique case (state_ff)
         ST_CLEAR: begin
            iss_in = iss_ff + CNT_W'(1);
            if (iss_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            iss_in   = '0;
            total_in = '0;
            if (accept && (req_item.action == ACT_DRAW)) begin
               uni_in   = req_item.uniform;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (rd_vld_ff) begin
               total_in = total_ff + TOT_W'(wgt_rdata);
            end
            if (!issuing && !rd_vld_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = PW'(uni_ff) * PW'(total_ff);
            if (total_ff == '0) begin
               rsp_in.sample       = '0;
               rsp_in.sample_index = '0;
               rsp_in.empty_table  = 1'b1;
               strobe_in           = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               state_in = ST_CEIL;
            end
         end
         ST_CEIL: begin
            // u*W <= P*2^32 holds exactly when ceil(u*W / 2^32) <= P
            need_in   = prod_ff[32 +: TOT_W] + TOT_W'(|prod_ff[31:0]);
            prefix_in = '0;
            iss_in    = '0;
            state_in  = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (rd_vld_ff) begin
               prefix_in = prefix_sum;
               if (need_ff <= prefix_sum) begin
                  rsp_in.sample       = out_rdata;
                  rsp_in.sample_index = 8'(rd_idx_ff);
                  rsp_in.empty_table  = 1'b0;
                  strobe_in           = 1'b1;
                  state_in            = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         iss_ff    <= '0;
         rd_vld_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iss_ff    <= iss_in;
         rd_vld_ff <= rd_vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      total_ff  <= total_in;
      prefix_ff <= prefix_in;
      need_ff   <= need_in;
      prod_ff   <= prod_in;
      uni_ff    <= uni_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: hw/rtl/discrete_inverse_cdf_sampler_unit.sv
`timescale 1ns / 1ps
// Top level of the discrete inverse-CDF sampler: count register, weight and
// outcome memories, sequencer. Uses dicdf_pkg, dicdf_ram, dicdf_walker.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------
//   request  | start / busy        | req_item
//   response | rsp_strobe (1 cyc)  | rsp_item
//   csr      | csr_we              | csr_wdata
//
// A write item is written to both memories in the cycle it is accepted. A draw
// with n counted entries holds busy and strobes its result as busy falls: one
// memory read port walks the weights once to sum them and once more to find the
// entry, unless they sum to zero and an empty table is reported. After reset a
// clearing pass zeroes every weight memory entry with busy high.
// The result strobes for one cycle and cannot be held off; the next item may
// start in that same cycle.
module discrete_inverse_cdf_sampler_unit
   import dicdf_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output logic       rsp_strobe,
   output rsp_type    rsp_item,
   input  logic       csr_we,
   input  logic [8:0] csr_wdata
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [8:0]       entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] count;
   logic             wgt_we, out_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [15:0]      wgt_wdata, wgt_rdata;
   logic [31:0]      out_wdata, out_rdata;

   assign entry_count_in = csr_we ? csr_wdata : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 9'd1;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // saturate the count at the table depth
   assign count = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entry_count_ff);

   dicdf_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_weight_ram (
      .clock (clock),
      .we    (wgt_we),
      .waddr (ram_waddr),
      .wdata (wgt_wdata),
      .raddr (ram_raddr),
      .rdata (wgt_rdata)
   );

   dicdf_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_outcome_ram (
      .clock (clock),
      .we    (out_we),
      .waddr (ram_waddr),
      .wdata (out_wdata),
      .raddr (ram_raddr),
      .rdata (out_rdata)
   );

   dicdf_walker #(.TABLE_DEPTH(TABLE_DEPTH)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .count      (count),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .wgt_we     (wgt_we),
      .out_we     (out_we),
      .ram_waddr  (ram_waddr),
      .wgt_wdata  (wgt_wdata),
      .out_wdata  (out_wdata),
      .ram_raddr  (ram_raddr),
      .wgt_rdata  (wgt_rdata),
      .out_rdata  (out_rdata)
   );

endmodule
